// ===== hdl/pid_aw_pkg.sv =====
package pid_aw_pkg;

  // Register map of the configuration port
  typedef enum logic [2:0] {
    REG_KP_GAIN   = 3'd0,
    REG_KI_COEF   = 3'd1,
    REG_D_POLE    = 3'd2,
    REG_D_GAIN    = 3'd3,
    REG_AW_COEF   = 3'd4,
    REG_OUT_LIMIT = 3'd5
  } cfg_reg_t;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 24;

  // Coefficient defaults after reset
  localparam logic [23:0] KP_GAIN_RST   = 24'd1425408;
  localparam logic [23:0] KI_COEF_RST   = 24'd285082;
  localparam logic [15:0] D_POLE_RST    = 16'd3855;
  localparam logic [23:0] D_GAIN_RST    = 24'd1676950;
  localparam logic [23:0] AW_COEF_RST   = 24'd32768;
  localparam logic [14:0] OUT_LIMIT_RST = 15'd5734;   // 1.4 in Q4.12

  // Wide signed type for sums ahead of 32-bit saturation
  typedef logic signed [47:0] wide_t;
  typedef logic signed [31:0] acc_t;

  localparam wide_t ACC_MAX = 48'sh0000_7FFF_FFFF;
  localparam wide_t ACC_MIN = 48'shFFFF_8000_0000;

  function automatic acc_t sat32(input wide_t x);
    acc_t r;
    if (x > ACC_MAX) begin
      r = ACC_MAX[31:0];
    end else if (x < ACC_MIN) begin
      r = ACC_MIN[31:0];
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/pid_antiwindup_step_unit.sv =====
// Path: an accepted input transaction passes the input register, then the result
// register. Throughput: one sample per cycle while no result is held; the loop
// through aw_coef*clamp_difference, the three-term sum and the clamp is combinational
// back into the clamp-difference register.
// Reset (rst, synchronous, active high): pipeline empty, integral, derivative,
// previous error and clamp difference zero, coefficients back to their defaults.
module pid_antiwindup_step_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration write port
  input  logic                                   cfg_wr_en,
  input  logic [pid_aw_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [pid_aw_pkg::CFG_DATA_W-1:0]      cfg_data,
  // sample channel
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [15:0]                     reference,
  input  logic signed [15:0]                     measured,
  input  logic                                   restart,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [15:0]                     drive,
  output logic                                   clamped
);

  // ---------------------------------------------------------------------------
  // Coefficient registers
  // ---------------------------------------------------------------------------
  logic [23:0] kp_gain;
  logic [23:0] ki_coef;
  logic [15:0] d_pole;
  logic [23:0] d_gain;
  logic [23:0] aw_coef;
  logic [14:0] out_limit;

  // Indexes past the last register fall to the default arm and are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain   <= pid_aw_pkg::KP_GAIN_RST;
      ki_coef   <= pid_aw_pkg::KI_COEF_RST;
      d_pole    <= pid_aw_pkg::D_POLE_RST;
      d_gain    <= pid_aw_pkg::D_GAIN_RST;
      aw_coef   <= pid_aw_pkg::AW_COEF_RST;
      out_limit <= pid_aw_pkg::OUT_LIMIT_RST;
    end else if (cfg_wr_en) begin
      unique case (pid_aw_pkg::cfg_reg_t'(cfg_index))
        pid_aw_pkg::REG_KP_GAIN:   kp_gain   <= cfg_data;
        pid_aw_pkg::REG_KI_COEF:   ki_coef   <= cfg_data;
        pid_aw_pkg::REG_D_POLE:    d_pole    <= cfg_data[15:0];
        pid_aw_pkg::REG_D_GAIN:    d_gain    <= cfg_data;
        pid_aw_pkg::REG_AW_COEF:   aw_coef   <= cfg_data;
        pid_aw_pkg::REG_OUT_LIMIT: out_limit <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: input register (s1) then result register.
  // s1 moves forward whenever the result register is empty or being drained.
  // A held result stalls s1; the input is refused only while s1 is full too.
  // ---------------------------------------------------------------------------
  logic s1_valid;
  logic advance;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Input register: error is formed on the way in (17-bit, cannot overflow).
  logic signed [16:0] s1_error;
  logic               s1_restart;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_error   <= 17'(reference) - 17'(measured);
      s1_restart <= restart;
    end
  end

  // ---------------------------------------------------------------------------
  // Controller state (updated together with the result register)
  // ---------------------------------------------------------------------------
  pid_aw_pkg::acc_t   integral_term;
  pid_aw_pkg::acc_t   derivative_term;
  pid_aw_pkg::acc_t   clamp_difference;
  logic signed [16:0] previous_error;

  // ---------------------------------------------------------------------------
  // Single-pass datapath. Products are Q.28; dropping the low 16 bits of a
  // two's complement product is a floor, which is the required rounding.
  // ---------------------------------------------------------------------------
  logic signed [41:0] p_prod;      // kp * e
  logic signed [41:0] ki_prod;     // ki * e'
  logic signed [56:0] aw_prod;     // aw * c'
  logic signed [48:0] pole_prod;   // pole * D'
  logic signed [17:0] e_diff;
  logic signed [17:0] dg_in;
  logic signed [42:0] dg_prod;     // dg * (e - e')  or  dg * e on restart

  logic signed [25:0] p_term;
  logic signed [25:0] ki_term;
  logic signed [40:0] aw_term;
  logic signed [32:0] pole_term;
  logic signed [26:0] dg_term;

  pid_aw_pkg::wide_t  i_sum;
  pid_aw_pkg::wide_t  d_sum;
  pid_aw_pkg::wide_t  v_sum;
  pid_aw_pkg::acc_t   i_next;
  pid_aw_pkg::acc_t   d_next;
  pid_aw_pkg::acc_t   v_val;
  pid_aw_pkg::acc_t   u_val;
  pid_aw_pkg::acc_t   c_next;
  logic signed [32:0] lim_pos;
  logic signed [32:0] lim_neg;
  logic signed [32:0] v_ext;
  logic               clip_next;

  assign p_prod    = 42'($signed({1'b0, kp_gain})) * 42'(s1_error);
  assign ki_prod   = 42'($signed({1'b0, ki_coef})) * 42'(previous_error);
  assign aw_prod   = 57'($signed({1'b0, aw_coef})) * 57'(clamp_difference);
  assign pole_prod = 49'($signed({1'b0, d_pole})) * 49'(derivative_term);
  assign e_diff    = 18'(s1_error) - 18'(previous_error);
  // restart ignores the stored error: the derivative kick is dg*e alone
  assign dg_in     = s1_restart ? 18'(s1_error) : e_diff;
  assign dg_prod   = 43'($signed({1'b0, d_gain})) * 43'(dg_in);

  assign p_term    = p_prod[41:16];
  assign ki_term   = ki_prod[41:16];
  assign aw_term   = aw_prod[56:16];
  assign pole_term = pole_prod[48:16];
  assign dg_term   = dg_prod[42:16];

  always_comb begin
    if (s1_restart) begin
      i_sum = '0;
      d_sum = pid_aw_pkg::wide_t'(dg_term);
    end else begin
      // forward rectangle on e' plus back-calculation from c'
      i_sum = pid_aw_pkg::wide_t'(integral_term) + pid_aw_pkg::wide_t'(ki_term)
            + pid_aw_pkg::wide_t'(aw_term);
      d_sum = pid_aw_pkg::wide_t'(pole_term) + pid_aw_pkg::wide_t'(dg_term);
    end
    i_next = pid_aw_pkg::sat32(i_sum);
    d_next = pid_aw_pkg::sat32(d_sum);
    v_sum  = pid_aw_pkg::wide_t'(p_term) + pid_aw_pkg::wide_t'(i_next)
           + pid_aw_pkg::wide_t'(d_next);
    v_val  = pid_aw_pkg::sat32(v_sum);
  end

  // Clamp to +/- out_limit; a sum exactly at the limit passes unclipped.
  assign lim_pos = $signed({18'd0, out_limit});
  assign lim_neg = -lim_pos;
  assign v_ext   = 33'(v_val);

  always_comb begin
    priority if (v_ext > lim_pos) begin
      u_val     = lim_pos[31:0];
      clip_next = 1'b1;
    end else if (v_ext < lim_neg) begin
      u_val     = lim_neg[31:0];
      clip_next = 1'b1;
    end else begin
      u_val     = v_val;
      clip_next = 1'b0;
    end
    c_next = pid_aw_pkg::sat32(pid_aw_pkg::wide_t'(u_val) - pid_aw_pkg::wide_t'(v_val));
  end

  // ---------------------------------------------------------------------------
  // State and result registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_term    <= '0;
      derivative_term  <= '0;
      clamp_difference <= '0;
      previous_error   <= '0;
    end else if (advance) begin
      integral_term    <= i_next;
      derivative_term  <= d_next;
      clamp_difference <= c_next;
      previous_error   <= s1_error;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive   <= u_val[15:0];
      clamped <= clip_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // Input side is never throttled while the result stage can move.
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("in_ready low although result stage is free");

  // The held clamp difference is nonzero exactly when the shown result clipped.
  a_clip_matches_diff: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (clamped == (clamp_difference != 32'sd0)))
    else $error("clamped flag disagrees with stored clamp difference");

  // A restart sample leaves the integral cleared.
  a_restart_clears_i: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_restart) |=> (integral_term == 32'sd0))
    else $error("integral not cleared by restart");

endmodule
